FILE: design/crc_frame_receiver_checker_core_defines.svh
// Assertion macros used by the checker file of the frame receiver block.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
`ifndef CRC_FRAME_RECEIVER_CHECKER_CORE_DEFINES_SVH
`define CRC_FRAME_RECEIVER_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CRCFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define CRCFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: design/crcfc_pkg.sv
// Package of the frame receiver: types, constants and the CRC-16/MODBUS byte update.
// Used by every RTL file of the block and by its checker.
`timescale 1ns / 1ps

package crcfc_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 16;
	localparam int COUNT_W = 17;
	localparam int CRC_W   = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
	localparam logic [LEN_W-1:0]   MAX_PAYLOAD_RST = 16'd499;
	localparam logic [CRC_W-1:0]   CRC_INIT        = 16'hFFFF;
	localparam logic [CRC_W-1:0]   CRC_POLY        = 16'hA001;
	localparam logic [BYTE_W-1:0]  MARK_A          = 8'hAA;
	localparam logic [BYTE_W-1:0]  MARK_B          = 8'h55;

	// Frame overhead: two header bytes, two length bytes, two CRC bytes.
	localparam logic [COUNT_W:0]   FRAME_OVERHEAD  = 18'd6;
	localparam logic [COUNT_W:0]   PAYLOAD_OFFSET  = 18'd4;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_PAYLOAD,
		CLS_CRC_HI,
		CLS_CRC_LO
	} byte_cls_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_MARKER = 2'd1,
		ST_BAD_LENGTH = 2'd2,
		ST_CRC_ERROR  = 2'd3
	} frame_status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} result_kind_t;

	// One classified word passed from the front end to the back end.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		byte_cls_t         cls;
		logic              fwd;
		frame_status_t     pre_status;
		logic [LEN_W-1:0]  length;
	} qent_t;

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] crc;
		crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		for (int k = 0; k < BYTE_W; k++) begin
			if (crc[0])
				crc = (crc >> 1) ^ CRC_POLY;
			else
				crc = crc >> 1;
		end
		return crc;
	endfunction

endpackage

FILE: design/crcfc_ifs.sv
// Channel interfaces of the frame receiver: input bytes, results and configuration.
// Payload types come from crcfc_pkg.
`timescale 1ns / 1ps

interface crcfc_in_if;
	logic                        valid;
	logic                        ready;
	logic [crcfc_pkg::BYTE_W-1:0] rx_byte;
	logic                        end_of_buffer;

	modport source (output valid, output rx_byte, output end_of_buffer, input ready);
	modport sink (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface crcfc_out_if;
	logic                        valid;
	logic                        ready;
	logic                        result_kind;
	logic [crcfc_pkg::BYTE_W-1:0] payload_byte;
	logic [1:0]                  frame_status;
	logic [crcfc_pkg::LEN_W-1:0]  payload_length;

	modport source (output valid, output result_kind, output payload_byte,
		output frame_status, output payload_length, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input frame_status, input payload_length, output ready);
endinterface

interface crcfc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [crcfc_pkg::LEN_W-1:0] max_payload;

	modport source (output valid, output max_payload, input ready);
	modport sink (input valid, input max_payload, output ready);
endinterface

FILE: design/crcfc_front.sv
// Front end of the frame receiver: tracks the byte offset, header, length field and
// trailer marker, and classifies each accepted word. Depends on crcfc_pkg and crcfc_ifs.
`timescale 1ns / 1ps

module crcfc_front (
	input  logic                clk,
	input  logic                arst_n,
	crcfc_in_if.sink            in_ch,
	crcfc_cfg_if.sink           cfg,
	output logic                push_valid,
	input  logic                push_ready,
	output crcfc_pkg::qent_t    push_data
);
	import crcfc_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic               header_good_q;
	logic [LEN_W-1:0]   length_q;
	logic [BYTE_W-1:0]  prev_q;
	logic [LEN_W-1:0]   max_payload_q;

	logic               accept;
	logic               hg_n;
	logic [LEN_W-1:0]   len_n;
	logic [COUNT_W-1:0] cnt_n;
	logic [COUNT_W:0]   pay_end;
	logic [COUNT_W:0]   idx;
	byte_cls_t          cls;
	logic               max_ok;
	logic               len_fits;
	logic               marker_ok;

	assign accept    = in_ch.valid && push_ready;
	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid;
	assign cfg.ready   = 1'b1;

	always_comb begin
		hg_n  = header_good_q;
		len_n = length_q;
		case (count_q)
			17'd0: hg_n = (in_ch.rx_byte == MARK_A);
			17'd1: hg_n = header_good_q && (in_ch.rx_byte == MARK_B);
			17'd2: len_n = {in_ch.rx_byte, length_q[BYTE_W-1:0]};
			17'd3: len_n = {length_q[LEN_W-1:BYTE_W], in_ch.rx_byte};
			default: ;
		endcase
	end

	// Offsets are compared one bit wider so that 5 + length never wraps.
	assign idx     = {1'b0, count_q};
	assign pay_end = {{(COUNT_W+1-LEN_W){1'b0}}, length_q} + PAYLOAD_OFFSET;

	always_comb begin
		cls = CLS_NONE;
		if (count_q >= 17'd4) begin
			if (idx < pay_end)
				cls = CLS_PAYLOAD;
			else if (idx == pay_end)
				cls = CLS_CRC_HI;
			else if (idx == pay_end + 18'd1)
				cls = CLS_CRC_LO;
		end
	end

	assign cnt_n     = (count_q == COUNT_MAX) ? count_q : count_q + 17'd1;
	assign max_ok    = (len_n <= max_payload_q);
	assign len_fits  = ({{(COUNT_W+1-LEN_W){1'b0}}, len_n} + FRAME_OVERHEAD) <= {1'b0, cnt_n};
	assign marker_ok = hg_n && (prev_q == MARK_B) && (in_ch.rx_byte == MARK_A);

	always_comb begin
		push_data.data   = in_ch.rx_byte;
		push_data.last   = in_ch.end_of_buffer;
		push_data.cls    = cls;
		push_data.fwd    = (cls == CLS_PAYLOAD) && hg_n && max_ok && !in_ch.end_of_buffer;
		push_data.length = len_n;
		if (cnt_n < 17'd6)
			push_data.pre_status = ST_BAD_LENGTH;
		else if (!marker_ok)
			push_data.pre_status = ST_BAD_MARKER;
		else if (!len_fits || !max_ok)
			push_data.pre_status = ST_BAD_LENGTH;
		else
			push_data.pre_status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			header_good_q <= 1'b0;
			length_q      <= '0;
			prev_q        <= '0;
		end else if (accept) begin
			if (in_ch.end_of_buffer) begin
				count_q       <= '0;
				header_good_q <= 1'b0;
				length_q      <= '0;
				prev_q        <= '0;
			end else begin
				count_q       <= cnt_n;
				header_good_q <= hg_n;
				length_q      <= len_n;
				prev_q        <= in_ch.rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg.valid) begin
			max_payload_q <= cfg.max_payload;
		end
	end

endmodule

FILE: design/crcfc_queue.sv
// Two-entry queue of classified words between the front end and the back end.
// Depends on crcfc_pkg for the entry type.
`timescale 1ns / 1ps

module crcfc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  crcfc_pkg::qent_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output crcfc_pkg::qent_t pop_data
);
	import crcfc_pkg::*;

	qent_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule

FILE: design/crcfc_back.sv
// Back end of the frame receiver: runs the CRC-16/MODBUS over payload words, captures
// the received CRC and drives the result register. Depends on crcfc_pkg and crcfc_ifs.
`timescale 1ns / 1ps

module crcfc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  crcfc_pkg::qent_t pop_data,
	crcfc_out_if.source      out_ch
);
	import crcfc_pkg::*;

	logic [CRC_W-1:0]  crc_q;
	logic [CRC_W-1:0]  crc_rx_q;
	logic [CRC_W-1:0]  crc_n;
	logic [CRC_W-1:0]  crc_rx_n;
	logic              out_valid_q;
	result_kind_t      kind_q;
	logic [BYTE_W-1:0] byte_q;
	frame_status_t     status_q;
	logic [LEN_W-1:0]  length_q;
	logic              produces;
	logic              pop;
	frame_status_t     status_n;

	assign produces  = pop_data.fwd || pop_data.last;
	// Words that give no result drain even while the result register is stalled.
	assign pop_ready = !out_valid_q || out_ch.ready || !produces;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		crc_n    = crc_q;
		crc_rx_n = crc_rx_q;
		case (pop_data.cls)
			CLS_PAYLOAD: crc_n = crc_byte(crc_q, pop_data.data);
			CLS_CRC_HI:  crc_rx_n = {pop_data.data, crc_rx_q[BYTE_W-1:0]};
			CLS_CRC_LO:  crc_rx_n = {crc_rx_q[CRC_W-1:BYTE_W], pop_data.data};
			default: ;
		endcase
		if (pop_data.pre_status == ST_OK && crc_rx_n != crc_n)
			status_n = ST_CRC_ERROR;
		else
			status_n = pop_data.pre_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_INIT;
			crc_rx_q <= '0;
		end else if (pop) begin
			if (pop_data.last) begin
				crc_q    <= CRC_INIT;
				crc_rx_q <= '0;
			end else begin
				crc_q    <= crc_n;
				crc_rx_q <= crc_rx_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && produces) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && produces) begin
			length_q <= pop_data.length;
			if (pop_data.last) begin
				kind_q   <= KIND_STATUS;
				byte_q   <= '0;
				status_q <= status_n;
			end else begin
				kind_q   <= KIND_PAYLOAD;
				byte_q   <= pop_data.data;
				status_q <= ST_OK;
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.result_kind    = kind_q;
	assign out_ch.payload_byte   = byte_q;
	assign out_ch.frame_status   = status_q;
	assign out_ch.payload_length = length_q;

endmodule

FILE: design/crc_frame_receiver_checker_core.sv
// Top level of the length-prefixed frame receiver with CRC-16/MODBUS check.
// Depends on crcfc_pkg, crcfc_ifs, crcfc_front, crcfc_queue and crcfc_back.
//
// The in_ch channel takes one received byte per word, with end_of_buffer set on the
// last byte of a buffer. The out_ch channel gives one word per payload byte of a
// frame whose header markers are good and whose length is within max_payload, and
// one status word for the last byte of every buffer (ok, bad marker, bad length or
// CRC mismatch), both with the length field read from the header.
// The cfg channel writes max_payload and is always ready; the value must be written
// only while idle, which the block itself does not enforce. An accepted in_ch word
// enters the queue and moves to the result register once it is free or being read.
// One byte is taken every cycle while the queue has room; the front end classifies
// it, a two-entry queue holds it and the back end applies the byte-wide CRC update.
// Reset clears the frame state, sets max_payload to 499 and empties the queue.
// When the receiver stalls, the result register holds its word and the queue fills;
// in_ch.ready drops once both queue entries are taken, and bytes that give no result
// keep draining past a stalled result register.
`timescale 1ns / 1ps

module crc_frame_receiver_checker_core (
	input  logic         clk,
	input  logic         arst_n,
	crcfc_in_if.sink     in_ch,
	crcfc_out_if.source  out_ch,
	crcfc_cfg_if.sink    cfg
);
	import crcfc_pkg::*;

	logic  push_valid;
	logic  push_ready;
	qent_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	qent_t pop_data;

	crcfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	crcfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	crcfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_ch    (out_ch)
	);

endmodule

FILE: design/crcfc_chk.sv
// Port-level checker for the frame receiver and the bind that attaches it.
// Depends on crcfc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "crc_frame_receiver_checker_core_defines.svh"

module crcfc_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         result_kind,
	input logic [crcfc_pkg::BYTE_W-1:0] payload_byte,
	input logic [1:0]                   frame_status,
	input logic [crcfc_pkg::LEN_W-1:0]  payload_length
);
	import crcfc_pkg::*;

	// A status word never carries a payload byte.
	`CRCFC_ASSERT_IMP(a_status_no_byte, clk, arst_n,
		out_valid && result_kind == KIND_STATUS, payload_byte == '0)

	// A payload word always carries the ok code.
	`CRCFC_ASSERT_IMP(a_payload_ok_code, clk, arst_n,
		out_valid && result_kind == KIND_PAYLOAD, frame_status == ST_OK)

	`CRCFC_ASSERT_NXT(a_out_hold_valid, clk, arst_n, out_valid && !out_ready, out_valid)

	`CRCFC_ASSERT_NXT(a_out_hold_word, clk, arst_n, out_valid && !out_ready,
		$stable(result_kind) && $stable(payload_byte) && $stable(frame_status) &&
		$stable(payload_length))

endmodule

bind crc_frame_receiver_checker_core crcfc_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.result_kind    (out_ch.result_kind),
	.payload_byte   (out_ch.payload_byte),
	.frame_status   (out_ch.frame_status),
	.payload_length (out_ch.payload_length)
);
